@@ rtl/core/vtq_pkg.sv @@
package vtq_pkg;

	localparam int NUM_CHANNELS_DEF = 2;

	localparam int RAW_W   = 10;
	localparam int MV_W    = 14;
	localparam int DELAY_W = 16;
	localparam int CHAN_W  = 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int MV_FULL  = 15000;
	localparam int ADC_FULL = 1023;
	localparam int PROD_W   = 24;

	localparam logic [MV_W-1:0]    ENTER_RESET = MV_W'(1100);
	localparam logic [MV_W-1:0]    EXIT_RESET  = MV_W'(11500);
	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(10);

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_RESCAN = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOW_ENTER     = 2'd0,
		REG_LOW_EXIT      = 2'd1,
		REG_QUALIFY_DELAY = 2'd2,
		REG_UNUSED        = 2'd3
	} cfg_reg_t;

endpackage

@@ rtl/core/voltage_threshold_qualifier_core.sv @@
// channel | signals                                                                   | dir
// --------+---------------------------------------------------------------------------+----
// in      | in_valid, in_stall, op, channel, raw_sample                               | in
// out     | out_valid, out_stall, out_channel, scaled_millivolts, low_flag, published | out
// cfg     | cfg_wr_en, cfg_index, cfg_data                                            | in
//
// One beat in per cycle, one beat out per cycle, unless out_stall holds a full output register;
// stages: scale multiply, divide by 1023, threshold and timer update.
// All three stages advance together while the output register is empty or taken.
// Reset clears the stage valids, per-channel state and restores register defaults.
// in_stall follows out_stall whenever the output register holds a beat.
module voltage_threshold_qualifier_core #(
	parameter int NUM_CHANNELS = vtq_pkg::NUM_CHANNELS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  vtq_pkg::op_t                      op,
	input  logic [vtq_pkg::CHAN_W-1:0]        channel,
	input  logic [vtq_pkg::RAW_W-1:0]         raw_sample,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [vtq_pkg::CHAN_W-1:0]        out_channel,
	output logic [vtq_pkg::MV_W-1:0]          scaled_millivolts,
	output logic                              low_flag,
	output logic                              published,
	input  logic                              cfg_wr_en,
	input  logic [vtq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vtq_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import vtq_pkg::*;

	logic                adv;
	logic                accept;

	logic [MV_W-1:0]     enter_q;
	logic [MV_W-1:0]     exit_q;
	logic [DELAY_W-1:0]  delay_q;

	logic                v_s1;
	op_t                 op_s1;
	logic [CHAN_W-1:0]   ch_s1;
	logic [PROD_W-1:0]   prod_s1;

	logic                v_s2;
	op_t                 op_s2;
	logic [CHAN_W-1:0]   ch_s2;
	logic [MV_W-1:0]     mv_s2;

	logic                out_valid_q;
	logic [CHAN_W-1:0]   out_channel_q;
	logic [MV_W-1:0]     mv_q;
	logic                flag_q;
	logic                pub_q;

	logic                pub_low_q [NUM_CHANNELS];
	logic                raw_low_q [NUM_CHANNELS];
	logic [DELAY_W-1:0]  timer_q   [NUM_CHANNELS];

	logic [PROD_W:0]     div_sum;
	logic [14:0]         div_q0;
	logic [PROD_W:0]     div_rem;
	logic [14:0]         div_q;

	logic                ch_ok;
	logic                cur_pub;
	logic                cur_raw;
	logic [DELAY_W-1:0]  cur_timer;
	logic                now_low;
	logic                nxt_pub;
	logic                nxt_raw;
	logic [DELAY_W-1:0]  nxt_timer;
	logic                pub_beat;
	logic                flag_beat;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_q <= ENTER_RESET;
			exit_q  <= EXIT_RESET;
			delay_q <= DELAY_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOW_ENTER:     enter_q <= cfg_data[MV_W-1:0];
				REG_LOW_EXIT:      exit_q  <= cfg_data[MV_W-1:0];
				REG_QUALIFY_DELAY: delay_q <= cfg_data[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// divide by 1023: series estimate, then one correction step
	always_comb begin
		div_sum = (PROD_W+1)'(prod_s1) + (PROD_W+1)'(prod_s1 >> 10)
			+ (PROD_W+1)'(prod_s1 >> 20);
		div_q0  = div_sum[PROD_W:10];
		div_rem = (PROD_W+1)'(prod_s1) + (PROD_W+1)'(div_q0)
			- ((PROD_W+1)'(div_q0) << 10);
		div_q   = (div_rem >= (PROD_W+1)'(ADC_FULL)) ? div_q0 + 15'd1 : div_q0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= accept;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= op;
			ch_s1   <= channel;
			prod_s1 <= (op == OP_SAMPLE) ? PROD_W'(raw_sample) * PROD_W'(MV_FULL) : '0;
			op_s2   <= op_s1;
			ch_s2   <= ch_s1;
			mv_s2   <= div_q[MV_W-1:0];
			out_channel_q <= ch_s2;
			mv_q          <= mv_s2;
			flag_q        <= flag_beat;
			pub_q         <= pub_beat;
		end
	end

	always_comb begin
		ch_ok     = 1'b0;
		cur_pub   = 1'b0;
		cur_raw   = 1'b0;
		cur_timer = '0;
		for (int i = 0; i < NUM_CHANNELS; i++) begin
			if (int'(ch_s2) == i) begin
				ch_ok     = 1'b1;
				cur_pub   = pub_low_q[i];
				cur_raw   = raw_low_q[i];
				cur_timer = timer_q[i];
			end
		end
	end

	always_comb begin
		now_low   = cur_pub ? (mv_s2 < exit_q) : (mv_s2 < enter_q);
		nxt_pub   = cur_pub;
		nxt_raw   = cur_raw;
		nxt_timer = cur_timer;
		pub_beat  = 1'b0;
		if (op_s2 == OP_RESCAN) begin
			nxt_timer = '0;
			nxt_raw   = cur_pub;
			pub_beat  = 1'b1;
		end else if (now_low != cur_raw) begin
			nxt_raw   = now_low;
			nxt_timer = delay_q;
			if (delay_q == '0) begin
				nxt_pub  = now_low;
				pub_beat = 1'b1;
			end
		end else if (cur_timer != '0) begin
			nxt_timer = cur_timer - DELAY_W'(1);
			if (cur_timer == DELAY_W'(1)) begin
				nxt_pub  = cur_raw;
				pub_beat = 1'b1;
			end
		end
		flag_beat = ch_ok && nxt_pub;
		pub_beat  = ch_ok && pub_beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				pub_low_q[i] <= 1'b0;
				raw_low_q[i] <= 1'b0;
				timer_q[i]   <= '0;
			end
		end else if (adv && v_s2) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (int'(ch_s2) == i) begin
					pub_low_q[i] <= nxt_pub;
					raw_low_q[i] <= nxt_raw;
					timer_q[i]   <= nxt_timer;
				end
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign out_channel       = out_channel_q;
	assign scaled_millivolts = mv_q;
	assign low_flag          = flag_q;
	assign published         = pub_q;

endmodule
